@@ sv/fdw_pkg.sv @@
// Shared types and constants of the flow packet duplicate filter.
package fdw_pkg;

    // Field widths fixed by the packet record
    localparam int SEC_W       = 32;
    localparam int USEC_W      = 20;
    localparam int TIME_W      = 52;
    localparam int HASH_PORT_W = 64;
    localparam int DUP_W       = 32;
    localparam int PW_W        = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [TIME_W-1:0] US_PER_SEC = 52'd1000000;
    localparam logic [USEC_W-1:0] TW_MAX     = 20'd999999;
    localparam logic [USEC_W-1:0] TW_RESET   = 20'd900000;
    localparam logic [PW_W-1:0]   PW_RESET   = 5'd0;
    localparam logic [DUP_W-1:0]  DUP_MAX    = 32'hFFFF_FFFF;

    // Register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_UNIQUE = 2'd0,
        VERDICT_DUP    = 2'd1,
        VERDICT_OOO    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [USEC_W-1:0] time_window;
        logic [PW_W-1:0]   packet_window;
    } cfg_t;

    // One packet after time conversion, queued for the walk engine
    typedef struct packed {
        logic                   flow_start;
        logic                   has_hash;
        logic [TIME_W-1:0]      now;
        logic [HASH_PORT_W-1:0] hash;
    } cmd_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [DUP_W-1:0] dup_total;
    } res_t;

endpackage

@@ sv/fdw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/fdw_fifo.sv @@
// Two-entry flop queue used between front, walk engine and result port.
module fdw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ sv/fdw_front.sv @@
// Input stage: takes packet beats and converts the arrival time to microseconds.
module fdw_front import fdw_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   flow_start,
    input  logic [SEC_W-1:0]       ts_sec,
    input  logic [USEC_W-1:0]      ts_usec,
    input  logic                   hash_present,
    input  logic [HASH_PORT_W-1:0] packet_hash,
    output logic                   cmd_push,
    output cmd_t                   cmd,
    input  logic                   cmd_full
);

    logic stage_valid_reg;
    cmd_t stage_reg;
    logic accept;

    assign full     = stage_valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = stage_valid_reg;
    assign cmd      = stage_reg;

    // Time conversion register; the multiply ends here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.flow_start <= flow_start;
            stage_reg.has_hash   <= hash_present;
            stage_reg.now        <= TIME_W'(ts_sec) * US_PER_SEC + TIME_W'(ts_usec);
            stage_reg.hash       <= hash_present ? packet_hash : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (!cmd_full)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

endmodule

@@ sv/fdw_walk.sv @@
// Walk engine: compares a packet against the history ring, newest first.
module fdw_walk import fdw_pkg::*; #(
    parameter int HISTORY_DEPTH = 16,
    parameter int HASH_BITS     = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_empty,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int LW     = (FW > PW_W) ? FW : PW_W;
    localparam int HASH_W = (HASH_BITS >= HASH_PORT_W) ? HASH_PORT_W : HASH_BITS;
    localparam int ENT_W  = 1 + HASH_W + TIME_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t            state_reg;
    cmd_t              item_reg;
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     cur_addr_reg;
    logic [FW-1:0]     fill_reg;
    logic [DUP_W-1:0]  dup_reg;
    logic [LW-1:0]     limit_reg;
    logic [LW-1:0]     idx_reg;
    verdict_t          verdict_reg;

    logic [FW-1:0]     fill_eff;
    logic [LW-1:0]     fill_ext;
    logic [LW-1:0]     pw_ext;
    logic [LW-1:0]     limit_calc;
    logic [AW-1:0]     rd_addr;
    logic [ENT_W-1:0]  ent;
    logic [ENT_W-1:0]  wr_ent;
    logic [TIME_W-1:0] ent_time;
    logic [HASH_W-1:0] ent_hash;
    logic              ent_hv;
    logic [TIME_W:0]   diff;
    logic [USEC_W-1:0] tw_eff;
    logic              is_late;
    logic              too_old;
    logic              match;
    logic              last;
    logic [DUP_W-1:0]  dup_new;
    logic              ram_we;

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        ptr_dec = (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        ptr_inc = (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    // Compare bound for the packet about to start
    assign fill_eff   = cmd.flow_start ? '0 : fill_reg;
    assign fill_ext   = LW'(fill_eff);
    assign pw_ext     = LW'(cfg.packet_window);
    assign limit_calc = (pw_ext != '0 && pw_ext < fill_ext) ? pw_ext : fill_ext;

    // History read: newest entry first, one entry per cycle
    assign rd_addr = (state_reg == ST_WALK) ? ptr_dec(cur_addr_reg) : ptr_dec(wr_ptr_reg);

    assign ent_time = ent[TIME_W-1:0];
    assign ent_hash = ent[TIME_W +: HASH_W];
    assign ent_hv   = ent[ENT_W-1];

    // Per-entry checks
    assign tw_eff  = (cfg.time_window > TW_MAX) ? TW_MAX : cfg.time_window;
    assign diff    = {1'b0, item_reg.now} - {1'b0, ent_time};
    assign is_late = diff[TIME_W];
    assign too_old = diff[TIME_W-1:0] > TIME_W'(tw_eff);
    assign match   = item_reg.has_hash && ent_hv && (ent_hash == item_reg.hash[HASH_W-1:0]);
    assign last    = ((idx_reg + LW'(1)) == limit_reg);

    // Result and history update
    assign dup_new  = (verdict_reg == VERDICT_DUP && dup_reg != DUP_MAX) ?
                      dup_reg + DUP_W'(1) : dup_reg;
    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_DONE) && !res_full;
    assign res      = '{verdict: verdict_reg, dup_total: dup_new};
    assign ram_we   = res_push && (verdict_reg != VERDICT_DUP);
    assign wr_ent   = {item_reg.has_hash, item_reg.hash[HASH_W-1:0], item_reg.now};

    fdw_ram #(
        .WIDTH(ENT_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_ptr_reg),
        .wdata(wr_ent),
        .raddr(rd_addr),
        .rdata(ent)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            item_reg     <= '0;
            wr_ptr_reg   <= '0;
            cur_addr_reg <= '0;
            fill_reg     <= '0;
            dup_reg      <= '0;
            limit_reg    <= '0;
            idx_reg      <= '0;
            verdict_reg  <= VERDICT_UNIQUE;
        end
        else
        begin
            cur_addr_reg <= rd_addr;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        item_reg    <= cmd;
                        limit_reg   <= limit_calc;
                        idx_reg     <= '0;
                        verdict_reg <= VERDICT_UNIQUE;
                        if (cmd.flow_start)
                        begin
                            fill_reg <= '0;
                            dup_reg  <= '0;
                        end
                        state_reg <= (limit_calc == '0) ? ST_DONE : ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (is_late)
                    begin
                        verdict_reg <= VERDICT_OOO;
                        state_reg   <= ST_DONE;
                    end
                    else if (too_old)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (match)
                    begin
                        verdict_reg <= VERDICT_DUP;
                        state_reg   <= ST_DONE;
                    end
                    else if (last)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!res_full)
                    begin
                        dup_reg <= dup_new;
                        if (verdict_reg != VERDICT_DUP)
                        begin
                            wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                            if (fill_reg != FILL_MAX)
                            begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/flow_packet_dedup_window_unit.sv @@
// Top level of the flow packet duplicate filter: config, queues and engine.
//
// Packets of one flow are pushed in with an arrival time and an optional
// content hash; for each one a verdict (unique, duplicate, out of order) and
// the flow's running duplicate count pop out, in order. The input stage
// converts the time to microseconds in a register. The walk engine
// takes a packet in ST_IDLE, compares k history entries in ST_WALK, where
// k is at most the smaller of the retained count and a nonzero packet_window,
// and hands the result on in ST_DONE. The history ring sits in one RAM with
// a single read port, walked one entry per cycle, newest first. Two-entry
// queues before and after the engine let the input and result sides stall
// independently. History needs no clearing pass: a fill count bounds the
// walk, and a flow start simply zeroes it.
module flow_packet_dedup_window_unit import fdw_pkg::*; #(
    parameter int HISTORY_DEPTH = 16,
    parameter int HASH_BITS     = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [USEC_W-1:0]      cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   flow_start,
    input  logic [SEC_W-1:0]       ts_sec,
    input  logic [USEC_W-1:0]      ts_usec,
    input  logic                   hash_present,
    input  logic [HASH_PORT_W-1:0] packet_hash,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             verdict,
    output logic [DUP_W-1:0]       dup_total
);

    cfg_t cfg_reg;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic res_push;
    logic res_full;
    res_t res_in;
    res_t res_out;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_window   <= TW_RESET;
            cfg_reg.packet_window <= PW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_WINDOW:
                begin
                    cfg_reg.time_window <= cfg_data;
                end
                CFG_PACKET_WINDOW:
                begin
                    cfg_reg.packet_window <= cfg_data[PW_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    fdw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .flow_start  (flow_start),
        .ts_sec      (ts_sec),
        .ts_usec     (ts_usec),
        .hash_present(hash_present),
        .packet_hash (packet_hash),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .cmd_full    (cmd_full)
    );

    fdw_fifo #(
        .WIDTH($bits(cmd_t))
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .din  (cmd_in),
        .full (cmd_full),
        .pop  (cmd_pop),
        .dout (cmd_out),
        .empty(cmd_empty)
    );

    fdw_walk #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .HASH_BITS    (HASH_BITS)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd_empty(cmd_empty),
        .cmd      (cmd_out),
        .cmd_pop  (cmd_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    fdw_fifo #(
        .WIDTH($bits(res_t))
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .din  (res_in),
        .full (res_full),
        .pop  (pop),
        .dout (res_out),
        .empty(empty)
    );

    assign verdict   = res_out.verdict;
    assign dup_total = res_out.dup_total;

    // Checks
    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_full) |=> (cmd_push && $stable(cmd_in)))
        else $error("front beat not held while command queue full");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed into full result queue");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_in.verdict == VERDICT_UNIQUE || res_in.verdict == VERDICT_DUP ||
                      res_in.verdict == VERDICT_OOO))
        else $error("undefined verdict code");

    a_dup_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_in.verdict == VERDICT_DUP) |-> (res_in.dup_total != '0))
        else $error("duplicate reported with zero count");

endmodule

@@ test/tb_flow_packet_dedup_window_unit.sv @@
// Testbench for the flow packet duplicate filter: predicted verdicts and duplicate counts checked per result beat.
`timescale 1ns / 1ps

module tb_flow_packet_dedup_window_unit;
    import fdw_pkg::*;

    localparam int HISTORY_DEPTH   = 16;
    localparam int HASH_BITS       = 64;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam logic [63:0] HASH_MASK = {64{1'b1}} >> (64 - HASH_BITS);
    localparam longint unsigned MAX_US = 64'd4294967295 * 64'd1000000 + 64'd999999;

    typedef struct {
        bit                     flow_start;
        logic [SEC_W-1:0]       sec;
        logic [USEC_W-1:0]      usec;
        bit                     has_hash;
        logic [HASH_PORT_W-1:0] hash;
    } packet_t;

    // Verdict predictor with its own copy of the history and registers
    class dedup_scoreboard;
        logic [USEC_W-1:0] time_window;
        logic [PW_W-1:0]   packet_window;
        logic [63:0]       kept_hash [HISTORY_DEPTH];
        logic [63:0]       kept_time [HISTORY_DEPTH];
        bit                kept_has_hash [HISTORY_DEPTH];
        int unsigned       kept_count;
        logic [DUP_W-1:0]  dup_count;
        res_t              expected_q [$];
        int unsigned       errors;

        function new();
            time_window   = TW_RESET;
            packet_window = PW_RESET;
            errors        = 0;
            dup_count     = '0;
            clear_history();
        endfunction

        function void clear_history();
            int i;
            for (i = 0; i < HISTORY_DEPTH; i++) begin
                kept_hash[i]     = '0;
                kept_time[i]     = '0;
                kept_has_hash[i] = 1'b0;
            end
            kept_count = 0;
        endfunction

        // Walk the history newest first and queue the expected result
        function void note_packet(packet_t p);
            logic [63:0] now_us;
            logic [63:0] past_us;
            logic [63:0] tw;
            logic [63:0] h;
            int unsigned span;
            int          i;
            verdict_t    v;
            res_t        r;
            if (p.flow_start) begin
                clear_history();
                dup_count = '0;
            end
            now_us = 64'(p.sec) * 64'd1000000 + 64'(p.usec);
            tw     = (time_window > TW_MAX) ? 64'(TW_MAX) : 64'(time_window);
            h      = p.hash & HASH_MASK;
            span   = kept_count;
            if (packet_window != 0 && 32'(packet_window) < span)
                span = 32'(packet_window);
            v = VERDICT_UNIQUE;
            for (i = 0; i < span; i++) begin
                past_us = kept_time[i];
                if (now_us < past_us) begin
                    v = VERDICT_OOO;
                    break;
                end
                if (now_us - past_us > tw)
                    break;
                if (p.has_hash && kept_has_hash[i] && kept_hash[i] == h) begin
                    v = VERDICT_DUP;
                    break;
                end
            end
            if (v == VERDICT_DUP) begin
                if (dup_count != DUP_MAX)
                    dup_count++;
            end else begin
                for (i = HISTORY_DEPTH - 1; i > 0; i--) begin
                    kept_hash[i]     = kept_hash[i-1];
                    kept_time[i]     = kept_time[i-1];
                    kept_has_hash[i] = kept_has_hash[i-1];
                end
                kept_hash[0]     = p.has_hash ? h : '0;
                kept_time[0]     = now_us;
                kept_has_hash[0] = p.has_hash;
                if (kept_count < HISTORY_DEPTH)
                    kept_count++;
            end
            r.verdict   = v;
            r.dup_total = dup_count;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] v, logic [DUP_W-1:0] d);
            res_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, verdict %0d dup_total %0d",
                         $time, v, d);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (v !== 2'(want.verdict)) begin
                $display("%0t: verdict expected %0d actual %0d", $time, want.verdict, v);
                errors++;
            end
            if (d !== want.dup_total) begin
                $display("%0t: dup_total expected %0d actual %0d", $time, want.dup_total, d);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [USEC_W-1:0]      cfg_data;
    logic                   push;
    logic                   full;
    logic                   flow_start;
    logic [SEC_W-1:0]       ts_sec;
    logic [USEC_W-1:0]      ts_usec;
    logic                   hash_present;
    logic [HASH_PORT_W-1:0] packet_hash;
    logic                   empty;
    logic                   pop;
    logic [1:0]             verdict;
    logic [DUP_W-1:0]       dup_total;

    dedup_scoreboard sb = new();

    bit              sender_idle   = 1'b1;
    bit              receiver_idle = 1'b1;
    bit              hold_off_req  = 1'b0;
    int              cycle_count   = 0;
    longint unsigned clock_us      = 0;
    logic [63:0]     hash_pool [$];

    flow_packet_dedup_window_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .HASH_BITS     (HASH_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .flow_start   (flow_start),
        .ts_sec       (ts_sec),
        .ts_usec      (ts_usec),
        .hash_present (hash_present),
        .packet_hash  (packet_hash),
        .empty        (empty),
        .pop          (pop),
        .verdict      (verdict),
        .dup_total    (dup_total)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one input beat; returns at the edge that accepts it, push left high
    task automatic offer_packet(input bit start, input logic [SEC_W-1:0] sec,
                                input logic [USEC_W-1:0] usec, input bit has_hash,
                                input logic [HASH_PORT_W-1:0] hash);
        packet_t p;
        p.flow_start = start;
        p.sec        = sec;
        p.usec       = usec;
        p.has_hash   = has_hash;
        p.hash       = hash;
        if (sender_idle && $urandom_range(0, 9) < 2) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push         <= 1'b1;
        flow_start   <= start;
        ts_sec       <= sec;
        ts_usec      <= usec;
        hash_present <= has_hash;
        packet_hash  <= hash;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_packet(p);
    endtask

    // Registers change only with nothing in flight
    task automatic write_config(input logic [USEC_W-1:0] tw, input logic [PW_W-1:0] pw);
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIME_WINDOW;
        cfg_data  <= tw;
        @(posedge clk);
        cfg_index <= CFG_PACKET_WINDOW;
        cfg_data  <= USEC_W'(pw);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.time_window   = tw;
        sb.packet_window = pw;
    endtask

    // Mostly a plausible flow: rising times near the window, reused hashes
    task automatic random_packet();
        longint unsigned t_us;
        longint unsigned gap;
        longint unsigned back;
        longint unsigned tw_eff;
        longint unsigned sec_part;
        longint unsigned usec_part;
        int unsigned     pick;
        int unsigned     depth;
        bit              start;
        bit              has_h;
        logic [63:0]     h;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            // noise: any field value at all
            offer_packet(1'($urandom_range(0, 1)), $urandom,
                         USEC_W'($urandom_range(0, 20'hFFFFF)),
                         1'($urandom_range(0, 1)), {$urandom, $urandom});
            return;
        end
        tw_eff = (sb.time_window > TW_MAX) ? 64'(TW_MAX) : 64'(sb.time_window);
        start  = (pick < 9);
        if (start) begin
            case ($urandom_range(0, 3))
                0:       clock_us = 0;
                1:       clock_us = (64'hFFFF_FFFF - 64'($urandom_range(0, 2))) * 64'd1000000;
                default: clock_us = 64'($urandom) * 64'd1000000 + 64'($urandom_range(0, 999999));
            endcase
            t_us = clock_us;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                gap = 0;
            else if (pick < 50)
                gap = 64'($urandom_range(1, 32'(tw_eff / 8 + 50)));
            else if (pick < 65) begin
                gap = tw_eff + 64'($urandom_range(0, 6));
                gap = (gap > 3) ? gap - 3 : 0;
            end else if (pick < 72)
                gap = 64'($urandom_range(1000000, 5000000));
            else
                gap = 64'($urandom_range(1, 32'(2 * tw_eff + 100)));
            if (pick >= 72 && pick < 82) begin
                // out of order: earlier than the newest kept packet
                back = 64'($urandom_range(1, 32'(tw_eff + 10)));
                t_us = (clock_us >= back) ? clock_us - back : clock_us;
            end else begin
                if (clock_us + gap > MAX_US)
                    clock_us = gap;
                else
                    clock_us = clock_us + gap;
                t_us = clock_us;
            end
        end
        sec_part  = t_us / 1000000;
        usec_part = t_us % 1000000;
        // same instant written with an oversized microsecond part
        if (sec_part > 0 && usec_part < 48576 && $urandom_range(0, 7) == 0) begin
            sec_part  = sec_part - 1;
            usec_part = usec_part + 1000000;
        end
        pick  = $urandom_range(0, 99);
        has_h = (pick >= 12);
        if (pick >= 12 && pick < 55 && hash_pool.size() != 0) begin
            depth = (hash_pool.size() < 20) ? hash_pool.size() : 20;
            h = hash_pool[hash_pool.size() - 1 - $urandom_range(0, depth - 1)];
        end else
            h = {$urandom, $urandom};
        if (has_h) begin
            hash_pool.push_back(h);
            if (hash_pool.size() > 24)
                void'(hash_pool.pop_front());
        end
        offer_packet(start, SEC_W'(sec_part), USEC_W'(usec_part), has_h, h);
    endtask

    // Result side: pops with random stalls, one long hold-off on request
    initial begin
        int hold_cycles;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                pop <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end else if (receiver_idle && $urandom_range(0, 9) < 2) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
                sb.check_result(verdict, dup_total);
        end
    end

    // Stimulus
    initial begin
        int                ph;
        int                n;
        int                count;
        logic [USEC_W-1:0] tw;
        logic [PW_W-1:0]   pw;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_TIME_WINDOW;
        cfg_data     <= '0;
        push         <= 1'b0;
        pop          <= 1'b0;
        flow_start   <= 1'b0;
        ts_sec       <= '0;
        ts_usec      <= '0;
        hash_present <= 1'b0;
        packet_hash  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings
        offer_packet(1'b1, 32'd0, 20'd0, 1'b1, 64'd0);
        offer_packet(1'b0, 32'd0, 20'd0, 1'b1, 64'd0);          // equal time, same hash
        offer_packet(1'b0, 32'd0, 20'd0, 1'b0, 64'd0);          // no hash never matches
        offer_packet(1'b0, 32'd0, 20'd0, 1'b1, 64'd0);          // walks past hashless entry
        offer_packet(1'b0, 32'd0, 20'd900000, 1'b1, 64'd0);     // gap exactly the window
        offer_packet(1'b0, 32'd0, 20'd900001, 1'b1, 64'd0);     // one past the window
        offer_packet(1'b0, 32'd0, 20'd500000, 1'b1, 64'd7);     // earlier than newest
        offer_packet(1'b0, 32'd0, 20'hFFFFF, 1'b1, {64{1'b1}}); // usec above one second
        offer_packet(1'b0, 32'd1, 20'd48575, 1'b1, {64{1'b1}}); // same instant, normal form
        offer_packet(1'b1, {32{1'b1}}, 20'd999999, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_packet(1'b0, {32{1'b1}}, 20'd999999, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_packet(1'b0, 32'h5555_5555, 20'h55555, 1'b1, 64'h5555_5555_5555_5555);
        offer_packet(1'b1, 32'hAAAA_AAAA, 20'hAAAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        clock_us = 0;

        // Random phases; every phase after the first writes its own register settings
        for (ph = 0; ph < 8; ph++) begin
            count = 170;
            case (ph)
                0: count = 130;
                1: begin tw = 20'd0;      pw = 5'd1;  count = 150; end
                2: begin tw = TW_MAX;     pw = 5'd16; count = 150; end
                3: begin tw = 20'hFFFFF;  pw = 5'd31; count = 150; end
                4: begin
                    tw = USEC_W'($urandom_range(50, 5000));
                    pw = PW_W'($urandom_range(2, 15));
                end
                5: begin tw = USEC_W'($urandom_range(0, 999999)); pw = 5'd0; end
                6: begin
                    tw = USEC_W'($urandom_range(100000, 400000));
                    pw = PW_W'($urandom_range(1, 31));
                end
                default: begin tw = TW_RESET; pw = PW_RESET; count = 250; end
            endcase
            if (ph != 0)
                write_config(tw, pw);
            sender_idle   = (ph != 3 && ph != 7);
            receiver_idle = (ph != 7);
            if (ph == 3)
                hold_off_req = 1'b1;
            for (n = 0; n < count; n++)
                random_packet();
        end
        push <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
